@@ hw/rtl/lscc_pkg.sv @@
// Shared types and constants for the lidar corridor check.
// Holds the sequencer state type, the CORDIC arctangent table and fixed bounds.
// No dependencies.
package lscc_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SUM,
        ST_SQRT,
        ST_VEC_INIT,
        ST_VEC,
        ST_BEAR,
        ST_DIV,
        ST_THETA,
        ST_ROT,
        ST_MUL_S,
        ST_MUL_C,
        ST_CMP,
        ST_DONE
    } lscc_state_t;

    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 5;

    // 23040 = 45 * 2^9: drop the power of two, then multiply by a reciprocal of 45
    localparam int DIV_SHIFT = 9;
    localparam int DIV_ODD   = 45;

    localparam logic [15:0] DIV_BIAS    = 16'd11520;
    localparam logic [15:0] NEAR_LO     = 16'd150;
    localparam logic [15:0] NEAR_HI     = 16'd650;
    localparam logic [15:0] FAR_LO      = 16'd700;
    localparam logic [15:0] FAR_HI      = 16'd2700;
    localparam logic [10:0] SAFE_RESET  = 11'd200;
    localparam logic [7:0]  GOAL_MARGIN = 8'd200;
    localparam logic [31:0] SIN_X0      = 32'd652032875;
    localparam logic [31:0] HALF_TURN32 = 32'h8000_0000;

    // atan(2^-i) in 2^-32 turn units
    function automatic logic [31:0] atan_turn32(input logic [STEP_W-1:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0:    v = 32'h20000000;
                5'd1:    v = 32'h12E4051E;
                5'd2:    v = 32'h09FB385B;
                5'd3:    v = 32'h051111D4;
                5'd4:    v = 32'h028B0D43;
                5'd5:    v = 32'h0145D7E1;
                5'd6:    v = 32'h00A2F61E;
                5'd7:    v = 32'h00517C55;
                5'd8:    v = 32'h0028BE53;
                5'd9:    v = 32'h00145F2F;
                5'd10:   v = 32'h000A2F98;
                5'd11:   v = 32'h000517CC;
                5'd12:   v = 32'h00028BE6;
                5'd13:   v = 32'h000145F3;
                5'd14:   v = 32'h0000A2FA;
                5'd15:   v = 32'h0000517D;
                5'd16:   v = 32'h000028BE;
                5'd17:   v = 32'h0000145F;
                5'd18:   v = 32'h00000A30;
                5'd19:   v = 32'h00000518;
                5'd20:   v = 32'h0000028C;
                5'd21:   v = 32'h00000146;
                5'd22:   v = 32'h000000A3;
                5'd23:   v = 32'h00000051;
                default: v = 32'h00000000;
            endcase
            return v;
        end
    endfunction

endpackage

@@ hw/rtl/lscc_if.sv @@
// Channel interfaces of the lidar corridor check: request, result, config.
// Valid/ready handshake; no package dependency.
interface lscc_req_if #(
    parameter int COORD_BITS = 20,
    parameter int ANGLE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic signed [COORD_BITS-1:0] goal_x;
    logic signed [COORD_BITS-1:0] goal_y;
    logic signed [COORD_BITS-1:0] robot_x;
    logic signed [COORD_BITS-1:0] robot_y;
    logic [ANGLE_BITS-1:0]        heading;
    logic [15:0]                  scan_distance;
    logic [14:0]                  scan_angle;
    logic                         last;

    modport source (output valid, cmd, goal_x, goal_y, robot_x, robot_y, heading,
                    scan_distance, scan_angle, last, input ready);
    modport sink   (input valid, cmd, goal_x, goal_y, robot_x, robot_y, heading,
                    scan_distance, scan_angle, last, output ready);
endinterface

interface lscc_rsp_if;
    logic valid;
    logic ready;
    logic path_clear;

    modport source (output valid, path_clear, input ready);
    modport sink   (input valid, path_clear, output ready);
endinterface

interface lscc_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] safe_zone_mm;

    modport source (output valid, safe_zone_mm, input ready);
    modport sink   (input valid, safe_zone_mm, output ready);
endinterface

@@ hw/rtl/laser_scan_path_clear_check.sv @@
// Top level of the lidar corridor check: sequencer plus one shared CORDIC shifter,
// one shared multiplier, a bit-serial sqrt and a reciprocal multiply for the angle.
// Depends on lscc_pkg and the interfaces in lscc_if.sv.
//
//  channel | dir | payload                                         | accept
//  req     | in  | cmd, goal/robot x,y, heading, scan, last        | valid & ready
//  rsp     | out | path_clear                                      | valid & ready
//  cfg     | in  | safe_zone_mm                                    | valid & ready
//
// Start item, after acceptance: two squares, sum, COORD_BITS+1 sqrt steps, vectoring
// setup, 24 vectoring CORDIC steps, bearing, done. Forward in-range sample: reciprocal
// multiply, theta, 24 rotation CORDIC steps, two multiplies, compare, done; other in-range
// samples: reciprocal multiply, theta, done; out-of-range: reciprocal multiply, done.
// req.ready is high only in idle; a last item waits in done while an earlier result is
// still unaccepted. Reset is asynchronous; cfg is always ready.
module laser_scan_path_clear_check #(
    parameter int ANGLE_BITS = 16,
    parameter int COORD_BITS = 20
) (
    input  logic       clk,
    input  logic       rst_n,
    lscc_req_if.sink   req,
    lscc_rsp_if.source rsp,
    lscc_cfg_if.sink   cfg
);
    import lscc_pkg::*;

    localparam int DW    = COORD_BITS + 1;
    localparam int RW    = 2 * DW;
    localparam int SRW   = DW + 3;
    localparam int NW    = ANGLE_BITS + 16;
    localparam int MW    = (DW > 32) ? DW : 32;
    localparam int PW    = 2 * MW;
    localparam int CW    = PW + 2;
    localparam int ZW    = 34;
    localparam int VSH   = 60 - COORD_BITS;
    localparam int CMAX  = (DW > CORDIC_STEPS) ? DW : CORDIC_STEPS;
    localparam int CNT_W = $clog2(CMAX + 1);
    localparam int RECIP_K = ANGLE_BITS + 13;
    localparam logic [63:0] RECIP = ((64'd1 << RECIP_K) + 64'(DIV_ODD - 1)) / 64'(DIV_ODD);
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-1:0] THREE_Q = ANGLE_BITS'(3) << (ANGLE_BITS - 2);

    lscc_state_t state_reg, state_next;

    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      last_reg, ranged_reg;
    logic signed [DW-1:0]      dx_reg, dy_reg;
    logic [ANGLE_BITS-1:0]     heading_reg;
    logic [15:0]               dist_reg;
    logic [NW-1:0]             num_reg, num_next;
    logic [ANGLE_BITS-1:0]     q_reg, q_next;
    logic [RW-1:0]             rad_reg, rad_next;
    logic [SRW-1:0]            srem_reg, srem_next;
    logic [DW-1:0]             root_reg, root_next;
    logic signed [63:0]        x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0]      z_reg, z_next;
    logic [PW-1:0]             prod_reg, prod_next;
    logic                      s_ok_reg, s_ok_next;
    logic [ANGLE_BITS-1:0]     bearing_reg, bearing_next;
    logic [DW-1:0]             gdist_reg, gdist_next;
    logic                      blocked_reg, blocked_next;
    logic [10:0]               sz_reg;
    logic                      out_valid_reg, out_valid_next;
    logic                      clear_reg, clear_next;

    logic                      accept;
    logic [DW-1:0]             ux, uy;
    logic [MW-1:0]             mul_a, mul_b;
    logic [PW-1:0]             mul_p;
    logic signed [63:0]        xs, ys;
    logic signed [ZW-1:0]      atan_z;
    logic                      rot_dir;
    logic [SRW-1:0]            srem_t, strial;
    logic [ANGLE_BITS-1:0]     theta;
    logic [ANGLE_BITS-1:0]     rot_a;
    logic [31:0]               zr;
    logic signed [63:0]        dy64;
    logic                      out_free;
    logic [15:0]               d_in;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.path_clear = clear_reg;
    assign out_free = !out_valid_reg || rsp.ready;
    assign d_in = req.scan_distance;

    assign ux = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
    assign uy = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);

    // shared CORDIC shifter and table
    assign xs     = x_reg >>> cnt_reg[STEP_W-1:0];
    assign ys     = y_reg >>> cnt_reg[STEP_W-1:0];
    assign atan_z = ZW'(atan_turn32(cnt_reg[STEP_W-1:0]));
    assign rot_dir = (state_reg == ST_VEC) ? !y_reg[63] : z_reg[ZW-1];

    // shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_SQ_X:  begin mul_a = MW'(ux); mul_b = MW'(ux); end
            ST_SQ_Y:  begin mul_a = MW'(uy); mul_b = MW'(uy); end
            ST_DIV:   begin mul_a = MW'(num_reg >> DIV_SHIFT); mul_b = MW'(RECIP); end
            ST_MUL_S: begin mul_a = MW'(dist_reg); mul_b = MW'(y_reg[31:0]); end
            ST_MUL_C: begin mul_a = MW'(dist_reg); mul_b = MW'(x_reg[31:0]); end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign srem_t = {srem_reg[SRW-3:0], rad_reg[RW-1:RW-2]};
    assign strial = SRW'({root_reg, 2'b01});
    assign theta  = bearing_reg + q_reg;
    assign rot_a  = (theta < QUARTER) ? theta : -theta;
    assign zr     = z_reg[31:0] + (32'd1 << (31 - ANGLE_BITS));
    assign dy64   = 64'(dy_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = req.cmd ? ST_DIV : ST_SQ_X;
            ST_SQ_X:     state_next = ST_SQ_Y;
            ST_SQ_Y:     state_next = ST_SUM;
            ST_SUM:      state_next = ST_SQRT;
            ST_SQRT:
                if (cnt_reg == CNT_W'(DW - 1))
                    state_next = ST_VEC_INIT;
            ST_VEC_INIT: state_next = ST_VEC;
            ST_VEC:
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                    state_next = ST_BEAR;
            ST_BEAR:     state_next = ST_DONE;
            ST_DIV:
                if (!ranged_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_THETA;
            ST_THETA:
                if (theta < QUARTER || theta > THREE_Q)
                    state_next = ST_ROT;
                else
                    state_next = ST_DONE;
            ST_ROT:
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                    state_next = ST_MUL_S;
            ST_MUL_S:    state_next = ST_MUL_C;
            ST_MUL_C:    state_next = ST_CMP;
            ST_CMP:      state_next = ST_DONE;
            ST_DONE:
                if (!last_reg || out_free)
                    state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cnt_next       = cnt_reg;
        num_next       = num_reg;
        q_next         = q_reg;
        rad_next       = rad_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        prod_next      = prod_reg;
        s_ok_next      = s_ok_reg;
        bearing_next   = bearing_reg;
        gdist_next     = gdist_reg;
        blocked_next   = blocked_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        clear_next     = clear_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                num_next = (NW'(req.scan_angle) << ANGLE_BITS) + NW'(DIV_BIAS);
                q_next   = '0;
            end
            ST_SQ_X:  prod_next = mul_p;
            ST_SQ_Y:
            begin
                rad_next  = RW'(prod_reg);
                prod_next = mul_p;
            end
            ST_SUM:
            begin
                rad_next  = rad_reg + RW'(prod_reg);
                srem_next = '0;
                root_next = '0;
                cnt_next  = '0;
            end
            ST_SQRT:
            begin
                rad_next = rad_reg << 2;
                if (srem_t >= strial)
                begin
                    srem_next = srem_t - strial;
                    root_next = {root_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    srem_next = srem_t;
                    root_next = {root_reg[DW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
            end
            ST_VEC_INIT:
            begin
                gdist_next = root_reg;
                cnt_next   = '0;
                x_next     = 64'(ux) <<< VSH;
                y_next     = (dx_reg[DW-1] ? -dy64 : dy64) <<< VSH;
                z_next     = dx_reg[DW-1] ? ZW'(HALF_TURN32) : '0;
            end
            ST_VEC, ST_ROT:
            begin
                if (rot_dir)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_z;
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_z;
                end
                cnt_next = cnt_reg + 1'b1;
            end
            ST_BEAR:
            begin
                // goal on robot: direction is zero
                if (dx_reg == '0 && dy_reg == '0)
                    bearing_next = -heading_reg;
                else
                    bearing_next = zr[31:32-ANGLE_BITS] - heading_reg;
                blocked_next = 1'b0;
            end
            ST_DIV:
                // low bits of the quotient; the angle wraps mod one turn
                q_next = mul_p[RECIP_K +: ANGLE_BITS];
            ST_THETA:
            begin
                cnt_next = '0;
                x_next   = 64'(SIN_X0);
                y_next   = '0;
                z_next   = ZW'(rot_a) << (32 - ANGLE_BITS);
            end
            ST_MUL_S:
            begin
                // clamp negative sine and cosine to zero
                if (y_reg[63])
                    y_next = '0;
                if (x_reg[63])
                    x_next = '0;
                prod_next = y_reg[63] ? PW'(0) : mul_p;
            end
            ST_MUL_C:
            begin
                s_ok_next = CW'(prod_reg) < (CW'(sz_reg) << 30);
                prod_next = x_reg[63] ? PW'(0) : mul_p;
            end
            ST_CMP:
                if (s_ok_reg &&
                    (CW'(prod_reg) + (CW'(GOAL_MARGIN) << 30)) < (CW'(gdist_reg) << 30))
                    blocked_next = 1'b1;
            ST_DONE:
                if (last_reg && out_free)
                begin
                    out_valid_next = 1'b1;
                    clear_next     = !blocked_reg;
                    blocked_next   = 1'b0;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            blocked_reg   <= 1'b0;
            bearing_reg   <= '0;
            gdist_reg     <= '0;
            sz_reg        <= SAFE_RESET;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            blocked_reg   <= blocked_next;
            bearing_reg   <= bearing_next;
            gdist_reg     <= gdist_next;
            cnt_reg       <= cnt_next;
            if (cfg.valid && cfg.ready)
                sz_reg <= cfg.safe_zone_mm;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg    <= req.last;
            dx_reg      <= DW'(req.goal_x) - DW'(req.robot_x);
            dy_reg      <= DW'(req.goal_y) - DW'(req.robot_y);
            heading_reg <= req.heading;
            dist_reg    <= d_in;
            ranged_reg  <= (d_in > NEAR_LO && d_in < NEAR_HI) ||
                           (d_in > FAR_LO && d_in < FAR_HI);
        end
        num_reg  <= num_next;
        q_reg    <= q_next;
        rad_reg  <= rad_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        prod_reg <= prod_next;
        s_ok_reg <= s_ok_next;
        clear_reg <= clear_next;
    end

endmodule
